// ===== hw/rtl/fcl_pkg.sv =====
// Shared types, codes and defaults for the fully connected layer.
`timescale 1ns / 1ps
package fcl_pkg;

	localparam int MAX_IN_DEF    = 256;
	localparam int MAX_OUT_DEF   = 64;
	localparam int DATA_BITS_DEF = 16;

	localparam int REG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;

	localparam logic [REG_IDX_W-1:0] REG_IN_COUNT    = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_OUT_COUNT   = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_BIAS_ENABLE = 2'd2;

	localparam logic [8:0] IN_COUNT_RST    = 9'd256;
	localparam logic [6:0] OUT_COUNT_RST   = 7'd64;
	localparam logic       BIAS_ENABLE_RST = 1'b1;

	localparam logic [1:0] OP_WEIGHT  = 2'd0;
	localparam logic [1:0] OP_BIAS    = 2'd1;
	localparam logic [1:0] OP_FEATURE = 2'd2;

	typedef struct packed {
		logic [1:0]         operation;
		logic [13:0]        address;
		logic signed [31:0] data_word;
		logic               row_end;
	} item_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic [5:0]         result_index;
		logic               last_of_row;
		logic               length_error;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BIAS,
		ST_MAC,
		ST_DRAIN,
		ST_EMIT,
		ST_ERR
	} state_t;

	typedef struct packed {
		logic start_row;
		logic bias_rd;
		logic issue;
		logic emit;
		logic emit_err;
	} cmd_t;

	typedef struct packed {
		logic feat_end;
		logic feat_ok;
		logic i_last;
		logic o_last;
		logic pipe_busy;
		logic out_free;
	} status_t;

endpackage

// ===== hw/rtl/fully_connected_layer_top.sv =====
// Fully connected layer: one shared multiply-accumulate over stored weights.
// Load and feature words take one cycle each while the block is idle.
// A row-closing feature of the right length starts one pass per output
// (bias read, n_in MAC issues, multiply/accumulate drain, result load);
// a wrong length gives one length-error result. Input stalls meanwhile.
// Reset clears control, counters and config (256, 64, 1); stores keep contents.
`timescale 1ns / 1ps
module fully_connected_layer_top #(
	parameter int MAX_IN    = fcl_pkg::MAX_IN_DEF,
	parameter int MAX_OUT   = fcl_pkg::MAX_OUT_DEF,
	parameter int DATA_BITS = fcl_pkg::DATA_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           write_enable,
	input  logic [fcl_pkg::REG_IDX_W-1:0]  register_index,
	input  logic [fcl_pkg::CFG_DATA_W-1:0] write_data,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  fcl_pkg::item_t                 item,
	output logic                           result_valid,
	input  logic                           result_stall,
	output fcl_pkg::result_t               result
);
	import fcl_pkg::*;

	cmd_t    cmd;
	status_t status;
	logic    busy;
	logic    accept;

	assign item_stall = busy;
	assign accept     = item_valid && !busy;

	fcl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	fcl_datapath #(
		.MAX_IN    (MAX_IN),
		.MAX_OUT   (MAX_OUT),
		.DATA_BITS (DATA_BITS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.write_enable   (write_enable),
		.register_index (register_index),
		.write_data     (write_data),
		.accept         (accept),
		.item           (item),
		.cmd            (cmd),
		.status         (status),
		.result_stall   (result_stall),
		.result_valid   (result_valid),
		.result         (result)
	);

endmodule

// ===== hw/rtl/fcl_ctrl.sv =====
// Row sequencer: walks outputs and inputs of one row through the shared MAC.
`timescale 1ns / 1ps
module fcl_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  fcl_pkg::status_t status,
	output fcl_pkg::cmd_t    cmd,
	output logic            busy
);
	import fcl_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (status.feat_end) begin
					state_d = status.feat_ok ? ST_BIAS : ST_ERR;
				end
			end
			ST_BIAS: begin
				state_d = ST_MAC;
			end
			ST_MAC: begin
				if (status.i_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!status.pipe_busy) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (status.out_free) begin
					state_d = status.o_last ? ST_IDLE : ST_BIAS;
				end
			end
			ST_ERR: begin
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy          = 1'b0;
				cmd.start_row = status.feat_end && status.feat_ok;
			end
			ST_BIAS: begin
				cmd.bias_rd = 1'b1;
			end
			ST_MAC: begin
				cmd.issue = 1'b1;
			end
			ST_DRAIN: begin
			end
			ST_EMIT: begin
				cmd.emit = status.out_free;
			end
			ST_ERR: begin
				cmd.emit_err = status.out_free;
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== hw/rtl/fcl_datapath.sv =====
// Stores, config registers, counters, MAC pipeline and result register.
`timescale 1ns / 1ps
module fcl_datapath #(
	parameter int MAX_IN    = fcl_pkg::MAX_IN_DEF,
	parameter int MAX_OUT   = fcl_pkg::MAX_OUT_DEF,
	parameter int DATA_BITS = fcl_pkg::DATA_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            write_enable,
	input  logic [fcl_pkg::REG_IDX_W-1:0]   register_index,
	input  logic [fcl_pkg::CFG_DATA_W-1:0]  write_data,
	input  logic                            accept,
	input  fcl_pkg::item_t                  item,
	input  fcl_pkg::cmd_t                   cmd,
	output fcl_pkg::status_t                status,
	input  logic                            result_stall,
	output logic                            result_valid,
	output fcl_pkg::result_t                result
);
	import fcl_pkg::*;

	localparam int WDEPTH = (MAX_IN * MAX_OUT < 16384) ? MAX_IN * MAX_OUT : 16384;
	localparam int WIW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
	localparam int BW     = $clog2(MAX_IN * MAX_OUT + 1);
	localparam int RIW    = (MAX_IN > 1) ? $clog2(MAX_IN) : 1;
	localparam int OIW    = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
	localparam int CW     = (RIW > 9) ? RIW : 9;
	localparam int PW     = 2 * DATA_BITS;

	localparam logic signed [32:0] DHI = (33'sd1 <<< (DATA_BITS - 1)) - 33'sd1;
	localparam logic signed [32:0] DLO = -DHI - 33'sd1;

	// config
	logic [8:0] in_count_q;
	logic [6:0] out_count_q;
	logic       bias_enable_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_count_q    <= IN_COUNT_RST;
			out_count_q   <= OUT_COUNT_RST;
			bias_enable_q <= BIAS_ENABLE_RST;
		end else if (write_enable) begin
			unique case (register_index)
				REG_IN_COUNT:    in_count_q    <= write_data;
				REG_OUT_COUNT:   out_count_q   <= write_data[6:0];
				REG_BIAS_ENABLE: bias_enable_q <= write_data[0];
				default: begin
				end
			endcase
		end
	end

	logic [8:0] n_in;
	logic [6:0] n_out;

	always_comb begin
		priority if (in_count_q == 9'd0) begin
			n_in = 9'd1;
		end else if (int'(in_count_q) > MAX_IN) begin
			n_in = 9'(MAX_IN);
		end else begin
			n_in = in_count_q;
		end
		priority if (out_count_q == 7'd0) begin
			n_out = 7'd1;
		end else if (int'(out_count_q) > MAX_OUT) begin
			n_out = 7'(MAX_OUT);
		end else begin
			n_out = out_count_q;
		end
	end

	// incoming word decode
	logic signed [32:0]          dw_x;
	logic signed [DATA_BITS-1:0] dsat;
	logic                        is_feat;
	logic                        wt_we;
	logic                        bias_we;
	logic                        row_we;
	logic [9:0]                  n_w;
	logic [8:0]                  elem_q;

	assign dw_x = 33'(item.data_word);

	always_comb begin
		priority if (dw_x > DHI) begin
			dsat = DHI[DATA_BITS-1:0];
		end else if (dw_x < DLO) begin
			dsat = DLO[DATA_BITS-1:0];
		end else begin
			dsat = dw_x[DATA_BITS-1:0];
		end
	end

	assign is_feat = accept && (item.operation == OP_FEATURE);
	assign wt_we   = accept && (item.operation == OP_WEIGHT) && (int'(item.address) < WDEPTH);
	assign bias_we = accept && (item.operation == OP_BIAS) && (int'(item.address) < MAX_OUT);
	assign row_we  = is_feat && (int'(elem_q) < MAX_IN);
	assign n_w     = {1'b0, elem_q} + 10'd1;

	assign status.feat_end = is_feat && ((n_w >= {1'b0, n_in}) || item.row_end);
	assign status.feat_ok  = (n_w == {1'b0, n_in}) && item.row_end;

	// counters
	logic [RIW-1:0] i_q;
	logic [OIW-1:0] o_q;
	logic [BW-1:0]  wbase_q;
	logic [8:0]     n_in_m1;
	logic [6:0]     n_out_m1;

	assign n_in_m1  = n_in - 9'd1;
	assign n_out_m1 = n_out - 7'd1;

	assign status.i_last = (CW'(i_q) == CW'(n_in_m1));
	assign status.o_last = (7'(o_q) == n_out_m1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elem_q  <= '0;
			i_q     <= '0;
			o_q     <= '0;
			wbase_q <= '0;
		end else begin
			if (is_feat) begin
				elem_q <= status.feat_end ? 9'd0 : n_w[8:0];
			end
			if (cmd.bias_rd) begin
				i_q <= '0;
			end else if (cmd.issue) begin
				i_q <= i_q + RIW'(1);
			end
			if (cmd.start_row) begin
				o_q     <= '0;
				wbase_q <= '0;
			end else if (cmd.emit) begin
				o_q     <= o_q + OIW'(1);
				wbase_q <= wbase_q + BW'(n_in);
			end
		end
	end

	// stores
	logic signed [DATA_BITS-1:0] wmem [WDEPTH];
	logic signed [DATA_BITS-1:0] rmem [MAX_IN];
	logic signed [31:0]          bmem [MAX_OUT];
	logic [BW-1:0]               wrd_addr;
	logic signed [DATA_BITS-1:0] wt_s1;
	logic signed [DATA_BITS-1:0] row_s1;
	logic signed [31:0]          bias_s1;

	assign wrd_addr = wbase_q + BW'(i_q);

	always_ff @(posedge clk) begin
		if (wt_we) begin
			wmem[item.address[WIW-1:0]] <= dsat;
		end
		if (cmd.issue) begin
			wt_s1 <= wmem[wrd_addr[WIW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (row_we) begin
			rmem[RIW'(elem_q)] <= dsat;
		end
		if (cmd.issue) begin
			row_s1 <= rmem[i_q];
		end
	end

	always_ff @(posedge clk) begin
		if (bias_we) begin
			bmem[item.address[OIW-1:0]] <= item.data_word;
		end
		if (cmd.bias_rd) begin
			bias_s1 <= bmem[o_q];
		end
	end

	// MAC pipeline
	logic                 v1_s1;
	logic                 v2_s2;
	logic signed [PW-1:0] prod_s2;
	logic signed [63:0]   prod_x;
	logic signed [63:0]   acc_q;
	logic [64:0]          sum;
	logic signed [63:0]   sum_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
		end else begin
			v1_s1 <= cmd.issue;
			v2_s2 <= v1_s1;
		end
	end

	assign status.pipe_busy = v1_s1 || v2_s2;

	always_ff @(posedge clk) begin
		prod_s2 <= row_s1 * wt_s1;
	end

	assign prod_x = 64'(prod_s2);
	assign sum    = {acc_q[63], acc_q} + {prod_x[63], prod_x};

	always_comb begin
		if (sum[64] != sum[63]) begin
			sum_sat = sum[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
		end else begin
			sum_sat = sum[63:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue && (i_q == '0)) begin
			acc_q <= bias_enable_q ? 64'(bias_s1) : 64'sd0;
		end else if (v2_s2) begin
			acc_q <= sum_sat;
		end
	end

	// result register
	logic signed [31:0] acc_sat;
	logic               result_valid_q;
	result_t            result_q;

	always_comb begin
		if ((&acc_q[63:31]) || !(|acc_q[63:31])) begin
			acc_sat = acc_q[31:0];
		end else begin
			acc_sat = acc_q[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end
	end

	assign status.out_free = !result_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.emit || cmd.emit_err) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			result_q.result_value <= acc_sat;
			result_q.result_index <= 6'(o_q);
			result_q.last_of_row  <= status.o_last;
			result_q.length_error <= 1'b0;
		end else if (cmd.emit_err) begin
			result_q.result_value <= 32'sd0;
			result_q.result_index <= 6'd0;
			result_q.last_of_row  <= 1'b1;
			result_q.length_error <= 1'b1;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
